/* design/albs_pkg.sv */
// albs_pkg: shared types and constants for the array search block
// no dependencies; imported by the controller, datapath and top level
package albs_pkg;

    // fixed field widths
    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;

    // apb port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    // register index
    localparam logic REG_ARRAY_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // parameter defaults
    localparam int DEF_STORE_DEPTH   = 1024;
    localparam int DEF_ELEMENT_WIDTH = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_LINEAR = 2'd1,
        REQ_BINARY = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_MID,
        RD_LO,
        RD_HI
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_LINEAR,
        OUT_LO,
        OUT_HI
    } t_out_sel;

    typedef struct packed {
        logic     start;
        logic     load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     scan_issue;
        logic     bin_step;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic lo_lt_hi;
        logic lo_in_len;
        logic data_eq;
        logic scan_last;
    } t_dp_sts;

endpackage

/* design/albs_datapath.sv */
// albs_datapath: element store, search bounds, scan pointer and result register
// depends on albs_pkg for command and status types
module albs_datapath
    import albs_pkg::*;
#(
    parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [LEN_W-1:0]         i_array_length,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [DATA_W-1:0] i_data_value,
    output t_dp_sts                  o_sts,
    output logic [LEN_W-1:0]         o_position,
    output logic                     o_found
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic signed [ELEMENT_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic signed [ELEMENT_WIDTH-1:0] r_rdata;
    logic signed [ELEMENT_WIDTH-1:0] r_key;
    logic signed [ELEMENT_WIDTH-1:0] n_key_in;

    logic [LEN_W-1:0] r_n;
    logic [LEN_W-1:0] r_lo;
    logic [LEN_W-1:0] r_hi;
    logic [LEN_W-1:0] r_scan;
    logic [LEN_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic [LEN_W-1:0] r_hit_pos;
    logic             r_hit;
    logic [LEN_W-1:0] r_position;
    logic             r_found;

    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] n_mid;
    logic [LEN_W-1:0] n_rd_idx;
    logic             n_load_ok;
    logic             n_eq;
    logic             n_key_gt;

    // sign-extend or truncate the 32-bit value to the element width
    assign n_key_in = ELEMENT_WIDTH'(i_data_value);

    // effective length: zero acts as one, clamp to the store depth
    always_comb begin
        n_len = i_array_length;
        if (i_array_length == '0) begin
            n_len = LEN_W'(1);
        end else if (int'(i_array_length) > STORE_DEPTH) begin
            n_len = LEN_W'(STORE_DEPTH);
        end
    end

    assign n_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign n_load_ok = int'(i_entry_index) < STORE_DEPTH;
    assign n_eq      = (r_rdata == r_key);
    assign n_key_gt  = (r_key > r_rdata);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SCAN: n_rd_idx = r_scan;
            RD_MID:  n_rd_idx = n_mid;
            RD_LO:   n_rd_idx = r_lo;
            RD_HI:   n_rd_idx = r_hi;
            default: n_rd_idx = r_scan;
        endcase
    end

    // single-port store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && n_load_ok) begin
            r_mem[ADDR_W'(i_entry_index)] <= n_key_in;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[ADDR_W'(n_rd_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= LEN_RESET;
            r_lo      <= '0;
            r_hi      <= '0;
            r_scan    <= '0;
            r_cmp_idx <= '0;
            r_cmp_vld <= 1'b0;
            r_hit_pos <= '0;
            r_hit     <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (i_cmd.start) begin
                r_key  <= n_key_in;
                r_n    <= n_len;
                r_lo   <= '0;
                r_hi   <= n_len - LEN_W'(1);
                r_scan <= '0;
                r_hit  <= 1'b0;
            end
            if (i_cmd.scan_issue) begin
                r_scan    <= r_scan + LEN_W'(1);
                r_cmp_idx <= r_scan;
            end
            // last matching position wins
            if (r_cmp_vld && n_eq) begin
                r_hit     <= 1'b1;
                r_hit_pos <= r_cmp_idx;
            end
            if (i_cmd.bin_step) begin
                if (n_eq) begin
                    r_lo <= n_mid;
                    r_hi <= n_mid;
                end else if (n_key_gt) begin
                    r_lo <= n_mid + LEN_W'(1);
                end else begin
                    r_hi <= (n_mid == '0) ? '0 : n_mid - LEN_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        case (i_cmd.out_sel)
            OUT_LINEAR: begin
                r_position <= r_hit ? r_hit_pos : r_n;
                r_found    <= r_hit;
            end
            OUT_LO: begin
                r_position <= r_lo;
                r_found    <= 1'b1;
            end
            OUT_HI: begin
                r_position <= r_hi;
                r_found    <= n_eq;
            end
            default: begin
            end
        endcase
    end

    // mid is registered implicitly: bounds only move on bin_step
    assign o_sts.lo_lt_hi  = (r_lo < r_hi);
    assign o_sts.lo_in_len = (r_lo < r_n);
    assign o_sts.data_eq   = n_eq;
    assign o_sts.scan_last = (r_scan == (r_n - LEN_W'(1)));

    assign o_position = r_position;
    assign o_found    = r_found;

`ifndef SYNTH
    a_step_needs_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bin_step |-> (r_lo < r_hi))
        else $error("binary step with closed bounds");

    a_scan_inside_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_issue |-> (r_scan < r_n))
        else $error("scan pointer past array length");

    a_hit_inside_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_sel == OUT_LINEAR && r_hit) |-> (r_hit_pos < r_n))
        else $error("linear hit position past array length");
`endif

endmodule

/* design/albs_ctrl.sv */
// albs_ctrl: sequencer for load, linear find and binary search transactions
// depends on albs_pkg for command and status types
module albs_ctrl
    import albs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic             i_out_stall,
    input  t_dp_sts          i_sts,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIN_RUN,
        S_LIN_DRAIN,
        S_LIN_DONE,
        S_BIN_CHECK,
        S_BIN_WAIT,
        S_BIN_LO,
        S_BIN_HI
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_in_accept;
    logic   n_out_free;

    assign n_in_accept = i_in_valid && (r_state == S_IDLE);
    assign n_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{start: 1'b0, load: 1'b0, rd_en: 1'b0, rd_sel: RD_SCAN,
                    scan_issue: 1'b0, bin_step: 1'b0, out_sel: OUT_NONE};
        case (r_state)
            S_IDLE: begin
                if (n_in_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_req_type == REQ_LINEAR) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_LIN_RUN;
                    end else if (i_req_type == REQ_BINARY) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_BIN_CHECK;
                    end
                end
            end
            S_LIN_RUN: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = RD_SCAN;
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LIN_DRAIN;
                end
            end
            S_LIN_DRAIN: begin
                n_state = S_LIN_DONE;
            end
            S_LIN_DONE: begin
                if (n_out_free) begin
                    o_cmd.out_sel = OUT_LINEAR;
                    n_state       = S_IDLE;
                end
            end
            S_BIN_CHECK: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.lo_lt_hi) begin
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_BIN_WAIT;
                end else if (i_sts.lo_in_len) begin
                    o_cmd.rd_sel = RD_LO;
                    n_state      = S_BIN_LO;
                end else begin
                    o_cmd.rd_sel = RD_HI;
                    n_state      = S_BIN_HI;
                end
            end
            S_BIN_WAIT: begin
                o_cmd.bin_step = 1'b1;
                n_state        = S_BIN_CHECK;
            end
            S_BIN_LO: begin
                if (!i_sts.data_eq) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HI;
                    n_state      = S_BIN_HI;
                end else if (n_out_free) begin
                    o_cmd.out_sel = OUT_LO;
                    n_state       = S_IDLE;
                end
            end
            S_BIN_HI: begin
                if (n_out_free) begin
                    o_cmd.out_sel = OUT_HI;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_sel != OUT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_sel != OUT_NONE) |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    a_find_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> o_in_stall)
        else $error("input taken while a find is in progress");
`endif

endmodule

/* design/array_linear_and_binary_search.sv */
// array_linear_and_binary_search: top level, apb register and channel ports
// depends on albs_pkg, albs_ctrl and albs_datapath
//
// Search engine over a store of STORE_DEPTH signed ELEMENT_WIDTH-bit elements.
// A load transaction (req_type 0) writes data_value into entry entry_index
// and gives no result; indexes at or above STORE_DEPTH are dropped.
// A linear-find transaction (req_type 1) reads the first n entries, one per
// cycle through the single read port of the store, and returns the last
// position holding the key, or n with found low when no entry matches. A
// binary-search transaction (req_type 2) assumes the first n entries are
// sorted ascending and returns the key's position, or the final upper search
// bound with found low; each halving step is a store read plus a bound
// update. n is the array_length register (byte address 0, reset 1), with 0
// read as 1 and values above STORE_DEPTH clamped. req_type 3 is dropped.
// The block takes one transaction at a time; the result register lets the
// next transaction start while a result is stalled.
// Entries never loaded read back as undefined.
module array_linear_and_binary_search
    import albs_pkg::*;
#(
    parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // apb configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,

    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [DATA_W-1:0] i_data_value,

    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [LEN_W-1:0]         o_position,
    output logic                     o_found
);

    logic [LEN_W-1:0] r_array_length;
    logic             n_reg_sel;
    logic             n_cfg_wr;
    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;

    // register index is the word address
    assign n_reg_sel = paddr[2];
    assign n_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_length <= LEN_RESET;
        end else if (n_cfg_wr && (n_reg_sel == REG_ARRAY_LENGTH)) begin
            r_array_length <= pwdata[LEN_W-1:0];
        end
    end

    // readback; addresses beyond the register list read as zero
    assign prdata = (n_reg_sel == REG_ARRAY_LENGTH) ? PDATA_W'(r_array_length) : '0;

    // sequencer: owns the handshakes and steps the datapath
    albs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // store, bounds, scan pointer and result register
    albs_datapath #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_array_length (r_array_length),
        .i_entry_index  (i_entry_index),
        .i_data_value   (i_data_value),
        .o_sts          (w_sts),
        .o_position     (o_position),
        .o_found        (o_found)
    );

endmodule
